/* hdl/lds_pkg.sv */
// ----------------------------------------------------------------------------
// lds_pkg
// Shared constants and helpers for the linear distribution random generator.
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int unsigned StateW = 32;
  localparam int unsigned RangeW = 16;
  localparam int unsigned FracW  = 17;

  localparam logic [StateW-1:0] LcgMul     = 32'd2891336453;
  localparam logic [StateW-1:0] LcgAdd     = 32'd1500450271;
  localparam logic [StateW-1:0] StateReset = 32'd2076571060;

  // one in Q1.16
  localparam logic [FracW-1:0] FracOne = 17'h10000;

  // configuration register indexes
  localparam logic CfgRange = 1'b0;
  localparam logic CfgLean  = 1'b1;

  // multiplier constant times a radix-4 digit, modulo 2^32
  function automatic logic [StateW-1:0] lcg_digit_mult(input logic [1:0] digit);
    logic [StateW-1:0] m2;
    m2 = {LcgMul[StateW-2:0], 1'b0};
    unique case (digit)
      2'd0:    lcg_digit_mult = '0;
      2'd1:    lcg_digit_mult = LcgMul;
      2'd2:    lcg_digit_mult = m2;
      default: lcg_digit_mult = m2 + LcgMul;
    endcase
  endfunction

endpackage

/* hdl/lds_req_if.sv */
// ----------------------------------------------------------------------------
// lds_req_if
// Request channel: operation code and seed value.
// ----------------------------------------------------------------------------
interface lds_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] seed_value;

  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

/* hdl/lds_res_if.sv */
// ----------------------------------------------------------------------------
// lds_res_if
// Result channel: one random value in unsigned Q16.16.
// ----------------------------------------------------------------------------
interface lds_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

/* hdl/lds_lcg.sv */
// ----------------------------------------------------------------------------
// lds_lcg
// Digit-serial LCG step: state * multiplier + increment, low 31 bits kept.
// ----------------------------------------------------------------------------
module lds_lcg import lds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [StateW-1:0] state_i,
  output logic              done_o,
  output logic [StateW-2:0] s_o
);

  typedef enum logic [1:0] {
    LcgIdle,
    LcgMult,
    LcgAdd_st
  } lcg_state_e;

  lcg_state_e        st_q;
  logic [StateW-1:0] sh_q;
  logic [StateW-1:0] acc_q;
  logic [3:0]        cnt_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LcgIdle;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        LcgIdle: begin
          if (start_i) begin
            sh_q  <= state_i;
            acc_q <= '0;
            cnt_q <= '0;
            st_q  <= LcgMult;
          end
        end
        LcgMult: begin
          // two state bits per cycle, msb first
          acc_q <= {acc_q[StateW-3:0], 2'b00} + lcg_digit_mult(sh_q[StateW-1 -: 2]);
          sh_q  <= {sh_q[StateW-3:0], 2'b00};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            st_q <= LcgAdd_st;
          end
        end
        default: begin
          acc_q  <= acc_q + LcgAdd;
          done_q <= 1'b1;
          st_q   <= LcgIdle;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign s_o    = acc_q[StateW-2:0];

endmodule

/* hdl/lds_sqrt.sv */
// ----------------------------------------------------------------------------
// lds_sqrt
// Bit-serial integer square root giving the Q1.16 fraction of a draw.
// ----------------------------------------------------------------------------
module lds_sqrt import lds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              lean_high_i,
  input  logic [StateW-2:0] s_i,
  output logic              done_o,
  output logic [FracW-1:0]  frac_o
);

  logic [33:0]      op_q;
  logic [17:0]      rem_q;
  logic [FracW-1:0] root_q;
  logic [4:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             lean_q;

  logic [32:0] radicand;
  logic [19:0] rem_sh;
  logic [19:0] trial;
  logic        fits;

  // high lean takes 2s, low lean takes 2^32 - 2s
  always_comb begin
    if (lean_high_i) begin
      radicand = {1'b0, s_i, 1'b0};
    end else begin
      radicand = 33'h1_0000_0000 - {1'b0, s_i, 1'b0};
    end
  end

  assign rem_sh = {rem_q, op_q[33:32]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        op_q   <= {1'b0, radicand};
        rem_q  <= '0;
        root_q <= '0;
        lean_q <= lean_high_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        op_q   <= {op_q[31:0], 2'b00};
        rem_q  <= fits ? 18'(rem_sh - trial) : rem_sh[17:0];
        root_q <= {root_q[FracW-2:0], fits};
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == 5'(FracW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign frac_o = lean_q ? root_q : FracOne - root_q;

endmodule

/* hdl/lds_mul.sv */
// ----------------------------------------------------------------------------
// lds_mul
// Bit-serial 16 x 16 multiplier, lsb first, one narrow add per cycle.
// ----------------------------------------------------------------------------
module lds_mul import lds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RangeW-1:0]   a_i,
  input  logic [RangeW-1:0]   b_i,
  output logic                done_o,
  output logic [2*RangeW-1:0] product_o
);

  logic [RangeW-1:0] a_q;
  logic [RangeW-1:0] hi_q;
  logic [RangeW-1:0] lo_q;
  logic [3:0]        cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [RangeW:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= a_i;
        hi_q   <= '0;
        lo_q   <= b_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        hi_q  <= sum[RangeW:1];
        lo_q  <= {sum[0], lo_q[RangeW-1:1]};
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(RangeW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

/* hdl/linear_distribution_random.sv */
// ----------------------------------------------------------------------------
// linear_distribution_random
// Triangular-density random generator: LCG, square root, range scaling.
// ----------------------------------------------------------------------------
// A seed request loads the generator state. A draw request runs three
// serial units one after the other: the LCG step (radix-4 digit steps plus
// the increment), a bit-serial square root and a bit-serial range multiply.
// Each unit hands off to the next through a registered done strobe, then the
// output register is loaded. The next request is taken once the result sits
// in the output register; a stalled result holds up a further draw only when
// it is still waiting at the end of that draw. Output is unsigned Q16.16
// below the configured range.
module linear_distribution_random import lds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [RangeW-1:0] cfg_data_i,
  lds_req_if.sink           req_i,
  lds_res_if.source         res_o
);

  typedef enum logic [2:0] {
    StIdle,
    StLcg,
    StSqrt,
    StMul,
    StFin
  } top_state_e;

  top_state_e        st_q;
  logic [StateW-1:0] gen_q;
  logic [RangeW-1:0] range_q;
  logic              lean_q;
  logic              out_valid_q;
  logic [StateW-1:0] out_data_q;

  logic                req_fire;
  logic                lcg_start, lcg_done;
  logic [StateW-2:0]   lcg_s;
  logic                sqrt_start, sqrt_done;
  logic [FracW-1:0]    frac;
  logic                mul_start, mul_done;
  logic [2*RangeW-1:0] product;
  logic [RangeW-1:0]   range_eff;
  logic [StateW-1:0]   result;
  logic                out_free;
  logic                out_load;

  assign req_i.ready = (st_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign lcg_start   = req_fire && !req_i.operation;
  assign sqrt_start  = (st_q == StLcg) && lcg_done;
  assign mul_start   = (st_q == StSqrt) && sqrt_done;

  // a zero range acts as one
  assign range_eff = (range_q == '0) ? RangeW'(1) : range_q;

  // a fraction of one or more would reach the range, so clamp below it
  assign result = frac[FracW-1] ? {RangeW'(range_eff - RangeW'(1)), {RangeW{1'b0}}}
                                : product;

  assign out_free = !out_valid_q || res_o.ready;
  assign out_load = (st_q == StFin) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RangeW'(1);
      lean_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRange: range_q <= cfg_data_i;
        default:  lean_q  <= cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      gen_q       <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: begin
          if (req_fire) begin
            if (req_i.operation) begin
              gen_q <= req_i.seed_value;
            end else begin
              st_q <= StLcg;
            end
          end
        end
        StLcg: begin
          if (lcg_done) begin
            gen_q <= {1'b0, lcg_s};
            st_q  <= StSqrt;
          end
        end
        StSqrt: begin
          if (sqrt_done) begin
            st_q <= StMul;
          end
        end
        StMul: begin
          if (mul_done) begin
            st_q <= StFin;
          end
        end
        default: begin
          if (out_free) begin
            out_data_q <= result;
            st_q       <= StIdle;
          end
        end
      endcase
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.random_value = out_data_q;

  lds_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lcg_start),
    .state_i (gen_q),
    .done_o  (lcg_done),
    .s_o     (lcg_s)
  );

  lds_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (sqrt_start),
    .lean_high_i (lean_q),
    .s_i         (lcg_s),
    .done_o      (sqrt_done),
    .frac_o      (frac)
  );

  lds_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (range_eff),
    .b_i       (frac[RangeW-1:0]),
    .done_o    (mul_done),
    .product_o (product)
  );

endmodule
